/* src/lfww_pkg.sv */
// Shared types and constants for the line folder with word wrap.
package lfww_pkg;

   localparam logic [7:0] CHAR_BLANK   = 8'd32;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [5:0] FOLD_RESET   = 6'd20;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic take;
      logic emit_rd;
      logic load_char;
      logic load_nl;
      logic cp_rd;
      logic cp_wr;
   } ctl_cmd_type;

   typedef struct packed {
      logic take_emit;
      logic take_nl;
      logic out_free;
      logic emit_more;
      logic nl_follow;
      logic copy_needed;
      logic copy_more;
   } dp_status_type;

endpackage

/* src/lfww_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lfww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lfww_datapath.sv */
// Datapath: line buffer, counters, fold decisions and the output register.
module lfww_datapath import lfww_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [5:0]    csr_wr_data,
   input  req_word_type  req_word,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word,
   input  ctl_cmd_type   cmd,
   output dp_status_type status
);

   localparam int DEPTH = MAX_WIDTH + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 2);

   logic [5:0]    fold_column_ff, fold_column_in;
   logic [CW-1:0] held_count_ff, held_count_in;
   logic          blank_seen_ff, blank_seen_in;
   logic [CW-1:0] blank_position_ff, blank_position_in;
   logic [7:0]    char_ff, char_in;
   logic [CW-1:0] emit_end_ff, emit_end_in;
   logic [CW-1:0] src_end_ff, src_end_in;
   logic [CW-1:0] cut_ff, cut_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          nl_follow_ff, nl_follow_in;
   logic          copy_needed_ff, copy_needed_in;
   logic          fix_ff, fix_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   logic [CW-1:0] width_now;
   logic          is_eos, is_nl, is_blank, is_full;
   logic          take_flush, take_fold, fold_blank;
   logic [CW-1:0] fold_cut, take_count;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   // A width of zero acts as one, and a width beyond MAX_WIDTH acts as MAX_WIDTH.
   always_comb begin
      if (fold_column_ff == 6'd0) begin
         width_now = CW'(1);
      end else if ({1'b0, fold_column_ff} > 7'(MAX_WIDTH)) begin
         width_now = CW'(MAX_WIDTH);
      end else begin
         width_now = CW'(fold_column_ff);
      end
   end

   assign is_eos     = req_word.end_of_stream;
   assign is_nl      = (req_word.char_in == CHAR_NEWLINE);
   assign is_blank   = (req_word.char_in == CHAR_BLANK);
   assign is_full    = (held_count_ff >= width_now);
   assign take_flush = is_eos | is_nl;
   assign take_fold  = !take_flush && is_full;
   assign fold_blank = blank_seen_ff | is_blank;
   assign fold_cut   = is_blank ? held_count_ff : blank_position_ff;
   assign take_count = (take_fold && fold_blank) ? fold_cut : held_count_ff;

   always_comb begin
      status.take_emit   = (take_flush || take_fold) && (take_count != '0);
      status.take_nl     = !is_eos && (is_nl || is_full);
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.emit_more   = (rd_idx_ff < emit_end_ff);
      status.nl_follow   = nl_follow_ff;
      status.copy_needed = copy_needed_ff;
      status.copy_more   = (rd_idx_ff <= src_end_ff);
   end

   always_comb begin
      fold_column_in    = fold_column_ff;
      held_count_in     = held_count_ff;
      blank_seen_in     = blank_seen_ff;
      blank_position_in = blank_position_ff;
      char_in           = char_ff;
      emit_end_in       = emit_end_ff;
      src_end_in        = src_end_ff;
      cut_in            = cut_ff;
      rd_idx_in         = rd_idx_ff;
      wr_idx_in         = wr_idx_ff;
      nl_follow_in      = nl_follow_ff;
      copy_needed_in    = copy_needed_ff;
      fix_in            = fix_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_word_in       = rsp_word_ff;

      if (csr_wr_en) begin
         fold_column_in = csr_wr_data;
      end

      if (cmd.take) begin
         char_in        = req_word.char_in;
         rd_idx_in      = '0;
         emit_end_in    = take_count;
         nl_follow_in   = status.take_nl;
         src_end_in     = held_count_ff;
         cut_in         = fold_cut;
         copy_needed_in = 1'b0;
         fix_in         = 1'b0;
         if (take_flush) begin
            held_count_in     = '0;
            blank_seen_in     = 1'b0;
            blank_position_in = '0;
         end else if (take_fold) begin
            copy_needed_in    = fold_blank && (fold_cut != held_count_ff);
            fix_in            = !fold_blank;
            held_count_in     = fold_blank ? (held_count_ff - fold_cut) : CW'(1);
            blank_seen_in     = 1'b0;
            blank_position_in = '0;
         end else begin
            held_count_in = held_count_ff + CW'(1);
            if (is_blank) begin
               blank_seen_in     = 1'b1;
               blank_position_in = held_count_ff;
            end
         end
      end

      if (cmd.emit_rd || cmd.cp_rd) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
      if (cmd.load_nl) begin
         rd_idx_in = cut_ff + CW'(1);
         wr_idx_in = '0;
      end
      if (cmd.cp_wr) begin
         wr_idx_in = wr_idx_ff + CW'(1);
      end

      if (cmd.load_char) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.char_out = ram_rd_data;
         rsp_word_in.last_of_run = (rd_idx_ff == emit_end_ff) && !nl_follow_ff;
      end else if (cmd.load_nl) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.char_out    = CHAR_NEWLINE;
         rsp_word_in.last_of_run = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_column_ff    <= FOLD_RESET;
         held_count_ff     <= '0;
         blank_seen_ff     <= 1'b0;
         blank_position_ff <= '0;
         rd_idx_ff         <= '0;
         wr_idx_ff         <= '0;
         nl_follow_ff      <= 1'b0;
         copy_needed_ff    <= 1'b0;
         fix_ff            <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         fold_column_ff    <= fold_column_in;
         held_count_ff     <= held_count_in;
         blank_seen_ff     <= blank_seen_in;
         blank_position_ff <= blank_position_in;
         rd_idx_ff         <= rd_idx_in;
         wr_idx_ff         <= wr_idx_in;
         nl_follow_ff      <= nl_follow_in;
         copy_needed_ff    <= copy_needed_in;
         fix_ff            <= fix_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      char_ff     <= char_in;
      emit_end_ff <= emit_end_in;
      src_end_ff  <= src_end_in;
      cut_ff      <= cut_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Write port: buffering a new character, restarting a line after a hard fold,
   // or moving the carried tail to the front of the buffer.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = held_count_ff[AW-1:0];
      ram_wr_data = req_word.char_in;
      if (cmd.take && !take_flush) begin
         ram_wr_en = 1'b1;
      end else if (cmd.load_nl && fix_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = '0;
         ram_wr_data = char_ff;
      end else if (cmd.cp_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_idx_ff[AW-1:0];
         ram_wr_data = ram_rd_data;
      end
   end

   assign ram_rd_en   = cmd.emit_rd | cmd.cp_rd;
   assign ram_rd_addr = rd_idx_ff[AW-1:0];

   lfww_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* src/lfww_controller.sv */
// Controller: sequences accept, emission, newline and tail copy.
module lfww_controller import lfww_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_WR   = 3'd2;
   localparam logic [2:0] S_NL   = 3'd3;
   localparam logic [2:0] S_CPR  = 3'd4;
   localparam logic [2:0] S_CPW  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.take_emit) begin
                  state_in = S_RD;
               end else if (status.take_nl) begin
                  state_in = S_NL;
               end
            end
         end
         S_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_WR;
         end
         S_WR: begin
            if (status.out_free) begin
               cmd.load_char = 1'b1;
               if (status.emit_more) begin
                  cmd.emit_rd = 1'b1;
               end else if (status.nl_follow) begin
                  state_in = S_NL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_NL: begin
            if (status.out_free) begin
               cmd.load_nl = 1'b1;
               state_in    = status.copy_needed ? S_CPR : S_IDLE;
            end
         end
         S_CPR: begin
            cmd.cp_rd = 1'b1;
            state_in  = S_CPW;
         end
         S_CPW: begin
            cmd.cp_wr = 1'b1;
            if (status.copy_more) begin
               cmd.cp_rd = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/line_folder_word_wrap_top.sv */
// Line folder with word wrap: folds a character stream into lines of at most
// fold_column characters, clamped to 1..MAX_WIDTH, breaking at the last blank
// where there is one. A character that only joins the buffered line leaves the
// block idle and ready for the next word. An item that flushes or folds the line
// emits the characters before the cut, then the newline unless the stream ends,
// then carries any tail after the last blank into the next line, and waits
// while the output is stalled. Every emitted or carried character passes through
// the single read port of the line buffer once. Words are accepted only while no
// fold or flush is in progress. The fold width resets to 20.
module line_folder_word_wrap_top import lfww_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [5:0]   csr_wr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   lfww_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfww_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_word    (req_word),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

/* src/lfww_checker.sv */
// Port-level checker for the line folder, bound to the top level.
module lfww_checker import lfww_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // Reset leaves no result word pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // Newlines are never buffered, so an emitted newline always ends its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.char_out == CHAR_NEWLINE) |-> rsp_word.last_of_run)
      else $error("newline word not marked last");

   // While a run is unfinished, no new input word is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_of_run |-> !req_ready)
      else $error("input taken in the middle of a run");

endmodule

bind line_folder_word_wrap_top lfww_checker u_lfww_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

/* bench/line_folder_word_wrap_top_tb.sv */
// Self-checking testbench for the line folder with word wrap: random text, stalls, fold widths.
`timescale 1ns / 100ps

module line_folder_word_wrap_top_tb;
   import lfww_pkg::*;

   localparam int unsigned LINE_MAX = 32;
   localparam int unsigned SETTLE = 2 * LINE_MAX + 16;
   localparam int unsigned LIMIT_CYCLES = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   req_word_type pending_words[$];
   rsp_word_type expected_chars[$];

   logic [7:0] line_buf [0:LINE_MAX];
   int unsigned held = 0;
   bit blank_seen = 1'b0;
   int unsigned blank_at = 0;
   logic [5:0] fold_reg = FOLD_RESET;

   bit calm_req = 1'b0;
   bit calm_rsp = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int errors = 0;
   int unsigned words_in = 0;
   int unsigned chars_out = 0;
   int unsigned folds = 0;
   int unsigned widths_written = 0;

   line_folder_word_wrap_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   always #10 clock = ~clock;

   function automatic int unsigned pick_wait(input bit calm);
      if (calm) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic int unsigned width_of(input logic [5:0] f);
      if (f == 6'd0) begin
         return 1;
      end
      if (f > LINE_MAX) begin
         return LINE_MAX;
      end
      return 32'(f);
   endfunction

   function automatic void expect_char(input logic [7:0] c);
      rsp_word_type r;
      r.char_out = c;
      r.last_of_run = 1'b0;
      expected_chars.push_back(r);
   endfunction

   function automatic void fold_predict(input req_word_type w);
      int unsigned base;
      int unsigned total;
      int unsigned j;
      base = expected_chars.size();
      if (w.end_of_stream) begin
         for (int unsigned k = 0; k < held; k++) begin
            expect_char(line_buf[k]);
         end
         held = 0;
         blank_seen = 1'b0;
         blank_at = 0;
      end else if (w.char_in == CHAR_NEWLINE) begin
         for (int unsigned k = 0; k < held; k++) begin
            expect_char(line_buf[k]);
         end
         expect_char(CHAR_NEWLINE);
         held = 0;
         blank_seen = 1'b0;
         blank_at = 0;
      end else if (held < width_of(fold_reg)) begin
         line_buf[held] = w.char_in;
         if (w.char_in == CHAR_BLANK) begin
            blank_seen = 1'b1;
            blank_at = held;
         end
         held++;
      end else begin
         folds++;
         total = held + 1;
         line_buf[held] = w.char_in;
         if (w.char_in == CHAR_BLANK) begin
            blank_seen = 1'b1;
            blank_at = held;
         end
         if (blank_seen) begin
            for (int unsigned k = 0; k < blank_at; k++) begin
               expect_char(line_buf[k]);
            end
            expect_char(CHAR_NEWLINE);
            j = 0;
            for (int unsigned k = blank_at + 1; k < total; k++) begin
               line_buf[j] = line_buf[k];
               j++;
            end
            held = j;
         end else begin
            for (int unsigned k = 0; k < held; k++) begin
               expect_char(line_buf[k]);
            end
            expect_char(CHAR_NEWLINE);
            line_buf[0] = w.char_in;
            held = 1;
         end
         blank_seen = 1'b0;
         blank_at = 0;
      end
      if (expected_chars.size() > base) begin
         expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   always @(posedge clock) begin : driver
      logic fire;
      fire = req_valid && req_ready;
      if (fire && !reset) begin
         fold_predict(req_word);
         words_in++;
      end
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || fire) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_words.size() != 0) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
            req_gap <= pick_wait(calm_req);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic take;
      int unsigned w;
      rsp_word_type want;
      take = rsp_valid && rsp_ready && !reset;
      if (take) begin
         chars_out++;
         if (expected_chars.size() == 0) begin
            $error("unexpected word: char_out %0d last_of_run %0b",
                   rsp_word.char_out, rsp_word.last_of_run);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_word.char_out !== want.char_out) begin
               $error("char_out: expected %0d, actual %0d", want.char_out, rsp_word.char_out);
               errors++;
            end
            if (rsp_word.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, actual %0b",
                      want.last_of_run, rsp_word.last_of_run);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         w = take ? pick_wait(calm_rsp) : rsp_wait;
         if (w != 0) begin
            rsp_ready <= 1'b0;
            rsp_wait <= w - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_wait <= 0;
         end
      end
   end

   task automatic queue_char(input logic [7:0] c);
      req_word_type w;
      w.char_in = c;
      w.end_of_stream = 1'b0;
      pending_words.push_back(w);
   endtask

   task automatic queue_eos();
      req_word_type w;
      w.char_in = 8'($urandom_range(0, 255));
      w.end_of_stream = 1'b1;
      pending_words.push_back(w);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_chars.size() != 0);
   endtask

   task automatic set_fold(input logic [5:0] v);
      wait_quiet();
      repeat (SETTLE) @(negedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      fold_reg = v;
      widths_written++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 99) < 75) begin
         return 8'h61 + 8'($urandom_range(0, 25));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_text(input int unsigned n);
      int unsigned count;
      int unsigned roll;
      int unsigned len;
      count = 0;
      while (count < n) begin
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            repeat (len) queue_char(text_byte());
            queue_char(CHAR_BLANK);
            count += len + 1;
         end else if (roll < 70) begin
            len = $urandom_range(1, 3);
            repeat (len) queue_char(CHAR_BLANK);
            count += len;
         end else if (roll < 80) begin
            queue_char(CHAR_NEWLINE);
            count++;
         end else if (roll < 85) begin
            queue_eos();
            count++;
         end else begin
            queue_char(8'($urandom_range(0, 255)));
            count++;
         end
         wait (pending_words.size() < 8);
      end
   endtask

   initial begin : stimulus
      int unsigned phase_widths[10];
      phase_widths = '{1, 7, 32, 0, 63, 33, 12, 20, 5, 2};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_eos();
      queue_char(CHAR_NEWLINE);
      queue_char("a");
      queue_char(CHAR_BLANK);
      queue_char("b");
      queue_char(CHAR_NEWLINE);
      queue_char(8'h00);
      queue_char(8'hFF);
      queue_eos();

      set_fold(6'd3);
      queue_char("x");
      queue_char("y");
      queue_char("z");
      queue_char("w");
      queue_char(CHAR_BLANK);
      queue_char("q");
      queue_char("r");
      queue_char(CHAR_BLANK);
      queue_char(CHAR_BLANK);
      queue_char(CHAR_BLANK);
      queue_char("m");
      queue_char("n");
      queue_char("o");

      set_fold(6'd1);
      queue_char("p");
      queue_eos();

      foreach (phase_widths[p]) begin
         set_fold(6'(phase_widths[p]));
         random_text(5);
         if (p == 2) begin
            wait_quiet();
         end
         random_text(4);
      end

      queue_eos();
      wait_quiet();
      repeat (SETTLE) @(negedge clock);
      $display("Sent %0d words and checked %0d output characters across %0d folds.",
               words_in, chars_out, folds);
      $display("Fold width was rewritten %0d times, from 0 up to 63.", widths_written);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 20);
      $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
src/lfww_pkg.sv
src/lfww_ram.sv
src/lfww_datapath.sv
src/lfww_controller.sv
src/line_folder_word_wrap_top.sv
src/lfww_checker.sv
bench/line_folder_word_wrap_top_tb.sv
